// File: rtl/core/xqv_pkg.sv
// ----------------------------------------------------------------------------
// XML QName validator package
// Shared types, constants and character class tables for the validator core.
// ----------------------------------------------------------------------------
package xqv_pkg;

   localparam int CP_WIDTH            = 21;
   localparam int LEN_OUT_W           = 16;
   localparam int REQ_DATA_W          = 8;
   localparam int RSP_DATA_W          = 40;
   localparam int MODE_W              = 2;
   localparam int DEFAULT_LENGTH_BITS = 16;
   localparam int DEFAULT_QUEUE_DEPTH = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_NAME   = 2'd0,
      MODE_NCNAME = 2'd1,
      MODE_QNAME  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      KIND_ASCII = 3'd0,
      KIND_LEAD2 = 3'd1,
      KIND_LEAD3 = 3'd2,
      KIND_LEAD4 = 3'd3,
      KIND_CONT  = 3'd4,
      KIND_BAD   = 3'd5
   } byte_kind_type;

   typedef struct packed {
      byte_kind_type          kind;
      logic [REQ_DATA_W-1:0]  data;
      logic                   last;
      logic                   empty;
   } item_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] lo;
      logic [CP_WIDTH-1:0] hi;
   } span_type;

   localparam int START_SPAN_COUNT = 16;
   localparam int EXTRA_SPAN_COUNT = 6;

   localparam span_type START_SPANS [START_SPAN_COUNT] = '{
      '{21'h0003A, 21'h0003A}, '{21'h00041, 21'h0005A},
      '{21'h0005F, 21'h0005F}, '{21'h00061, 21'h0007A},
      '{21'h000C0, 21'h000D6}, '{21'h000D8, 21'h000F6},
      '{21'h000F8, 21'h002FF}, '{21'h00370, 21'h0037D},
      '{21'h0037F, 21'h01FFF}, '{21'h0200C, 21'h0200D},
      '{21'h02070, 21'h0218F}, '{21'h02C00, 21'h02FEF},
      '{21'h03001, 21'h0D7FF}, '{21'h0F900, 21'h0FDCF},
      '{21'h0FDF0, 21'h0FFFD}, '{21'h10000, 21'hEFFFF}
   };

   localparam span_type EXTRA_SPANS [EXTRA_SPAN_COUNT] = '{
      '{21'h0002D, 21'h0002D}, '{21'h0002E, 21'h0002E},
      '{21'h00030, 21'h00039}, '{21'h000B7, 21'h000B7},
      '{21'h00300, 21'h0036F}, '{21'h0203F, 21'h02040}
   };

   localparam logic [CP_WIDTH-1:0] COLON_CP = 21'h0003A;

   function automatic logic is_start(input logic [CP_WIDTH-1:0] cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < START_SPAN_COUNT; i++) begin
         if (cp >= START_SPANS[i].lo && cp <= START_SPANS[i].hi) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic logic is_name_char(input logic [CP_WIDTH-1:0] cp);
      logic hit;
      hit = is_start(cp);
      for (int i = 0; i < EXTRA_SPAN_COUNT; i++) begin
         if (cp >= EXTRA_SPANS[i].lo && cp <= EXTRA_SPANS[i].hi) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

// File: rtl/core/xml_qname_validator_core.sv
// ----------------------------------------------------------------------------
// XML QName validator core
// Checks a UTF-8 byte stream against the XML Name, NCName or QName production.
// ----------------------------------------------------------------------------
// One request item carries one string byte; the item with tlast ends the
// string and produces one response item. The core takes one byte per cycle
// while the queue is not full: the front end classifies each byte and writes
// it into a queue of QUEUE_DEPTH items, and the back end decodes one queued
// item per cycle unless held by an untaken response, and registers the result
// in the response register when it pops the last item of a string. A response
// that is not taken stalls the back end only when the next string ends; until
// then the queue keeps absorbing bytes. The check mode register must be
// written only while no string is in flight.
module xml_qname_validator_core #(
   parameter int LENGTH_BITS = xqv_pkg::DEFAULT_LENGTH_BITS,
   parameter int QUEUE_DEPTH = xqv_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   // csr_wdata: check_mode
   input  logic [xqv_pkg::MODE_W-1:0]     csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // req_tdata: data_byte[7:0]
   input  logic [xqv_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tlast: end_of_string
   input  logic                           req_tlast,
   // req_tuser: empty_string
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // rsp_tdata: is_valid[0], has_prefix[1], prefix_length[17:2],
   // local_length[33:18], zero padding[39:34]
   output logic [xqv_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import xqv_pkg::*;

   logic     queue_full;
   logic     push;
   item_type push_item;
   logic     pop;
   logic     head_valid;
   item_type head_item;

   xqv_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   xqv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   xqv_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/core/xqv_front.sv
// ----------------------------------------------------------------------------
// XML QName validator front end
// Accepts request items and classifies each byte by its UTF-8 role.
// ----------------------------------------------------------------------------
module xqv_front (
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [xqv_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   input  logic                           req_tuser,
   input  logic                           queue_full,
   output logic                           push,
   output xqv_pkg::item_type              push_item
);
   import xqv_pkg::*;

   byte_kind_type kind;

   always_comb begin
      case (req_tdata) inside
         [8'h00:8'h7F]: kind = KIND_ASCII;
         [8'h80:8'hBF]: kind = KIND_CONT;
         [8'hC2:8'hDF]: kind = KIND_LEAD2;
         [8'hE0:8'hEF]: kind = KIND_LEAD3;
         [8'hF0:8'hF4]: kind = KIND_LEAD4;
         default:       kind = KIND_BAD;
      endcase
   end

   assign req_tready      = !queue_full;
   assign push            = req_tvalid && !queue_full;
   assign push_item.kind  = kind;
   assign push_item.data  = req_tdata;
   assign push_item.last  = req_tlast;
   assign push_item.empty = req_tuser;

endmodule

// File: rtl/core/xqv_queue.sv
// ----------------------------------------------------------------------------
// XML QName validator item queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module xqv_queue #(
   parameter int DEPTH = xqv_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  xqv_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output xqv_pkg::item_type head_item
);
   import xqv_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/xqv_back.sv
// ----------------------------------------------------------------------------
// XML QName validator back end
// Decodes UTF-8, checks name character classes and produces the result item.
// ----------------------------------------------------------------------------
module xqv_back #(
   parameter int LENGTH_BITS = xqv_pkg::DEFAULT_LENGTH_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [xqv_pkg::MODE_W-1:0]     csr_wdata,
   input  logic                           head_valid,
   input  xqv_pkg::item_type              head_item,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [xqv_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import xqv_pkg::*;

   mode_type               mode_ff, mode_in;
   logic [CP_WIDTH-1:0]    acc_ff, acc_in, acc_step, acc_shift;
   logic [1:0]             pend_ff, pend_in, pend_step;
   logic                   seg_first_ff, seg_first_in, seg_first_step;
   logic                   colon_ff, colon_in, colon_step;
   logic                   valid_ff, valid_in, valid_step;
   logic [LENGTH_BITS-1:0] cnt_ff, cnt_in, cnt_step;
   logic [LENGTH_BITS-1:0] prefix_ff, prefix_in, prefix_step;
   logic [LENGTH_BITS-1:0] local_bytes;
   logic [CP_WIDTH-1:0]    cp;
   logic                   cp_done;
   logic                   cont_err;
   logic                   is_colon;
   logic                   ok;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_valid_ff;
   logic                   out_prefix_ff;
   logic [LEN_OUT_W-1:0]   out_plen_ff;
   logic [LEN_OUT_W-1:0]   out_llen_ff;
   logic                   load_rsp;

   always_comb begin
      case (csr_wdata)
         MODE_NAME:   mode_in = MODE_NAME;
         MODE_NCNAME: mode_in = MODE_NCNAME;
         default:     mode_in = MODE_QNAME;
      endcase
   end

   assign pop      = head_valid && (!head_item.last || !rsp_valid_ff || rsp_tready);
   assign load_rsp = pop && head_item.last;

   assign acc_shift = {acc_ff[CP_WIDTH-7:0], head_item.data[5:0]};
   assign cont_err  = (head_item.kind != KIND_CONT)
                   || (pend_ff == 2'd2 && acc_ff == '0 && head_item.data < 8'hA0)
                   || (pend_ff == 2'd3 && acc_ff == '0 && head_item.data < 8'h90)
                   || (pend_ff == 2'd3 && acc_ff == CP_WIDTH'(4) && head_item.data > 8'h8F);

   always_comb begin
      acc_step       = acc_ff;
      pend_step      = pend_ff;
      seg_first_step = seg_first_ff;
      colon_step     = colon_ff;
      valid_step     = valid_ff;
      cnt_step       = cnt_ff;
      prefix_step    = prefix_ff;
      cp             = acc_shift;
      cp_done        = 1'b0;
      is_colon       = 1'b0;
      if (!head_item.empty) begin
         if (&cnt_ff) begin
            valid_step = 1'b0;
         end else begin
            cnt_step = cnt_ff + 1'b1;
         end
         if (pend_ff == 2'd0) begin
            case (head_item.kind)
               KIND_ASCII: begin
                  cp      = {{(CP_WIDTH-8){1'b0}}, head_item.data};
                  cp_done = 1'b1;
               end
               KIND_LEAD2: begin
                  acc_step  = {{(CP_WIDTH-5){1'b0}}, head_item.data[4:0]};
                  pend_step = 2'd1;
               end
               KIND_LEAD3: begin
                  acc_step  = {{(CP_WIDTH-4){1'b0}}, head_item.data[3:0]};
                  pend_step = 2'd2;
               end
               KIND_LEAD4: begin
                  acc_step  = {{(CP_WIDTH-3){1'b0}}, head_item.data[2:0]};
                  pend_step = 2'd3;
               end
               default: begin
                  valid_step = 1'b0;
               end
            endcase
         end else if (cont_err) begin
            valid_step = 1'b0;
            pend_step  = 2'd0;
            acc_step   = '0;
         end else begin
            acc_step  = acc_shift;
            pend_step = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               cp       = acc_shift;
               cp_done  = 1'b1;
               acc_step = '0;
            end
         end
      end
      if (cp_done) begin
         is_colon = (cp == COLON_CP) && (mode_ff != MODE_NAME);
         if (is_colon) begin
            if (mode_ff == MODE_NCNAME || colon_ff || seg_first_ff) begin
               valid_step = 1'b0;
            end else begin
               colon_step     = 1'b1;
               prefix_step    = cnt_ff;
               seg_first_step = 1'b1;
            end
         end else begin
            if (seg_first_ff ? !is_start(cp) : !is_name_char(cp)) begin
               valid_step = 1'b0;
            end
            seg_first_step = 1'b0;
         end
      end
   end

   assign ok          = valid_step && (pend_step == 2'd0) && !seg_first_step;
   assign local_bytes = colon_step ? cnt_step - prefix_step - 1'b1 : cnt_step;

   always_comb begin
      if (head_item.last) begin
         acc_in       = '0;
         pend_in      = 2'd0;
         seg_first_in = 1'b1;
         colon_in     = 1'b0;
         valid_in     = 1'b1;
         cnt_in       = '0;
         prefix_in    = '0;
      end else begin
         acc_in       = acc_step;
         pend_in      = pend_step;
         seg_first_in = seg_first_step;
         colon_in     = colon_step;
         valid_in     = valid_step;
         cnt_in       = cnt_step;
         prefix_in    = prefix_step;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NAME;
         acc_ff       <= '0;
         pend_ff      <= 2'd0;
         seg_first_ff <= 1'b1;
         colon_ff     <= 1'b0;
         valid_ff     <= 1'b1;
         cnt_ff       <= '0;
         prefix_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= mode_in;
         end
         if (pop) begin
            acc_ff       <= acc_in;
            pend_ff      <= pend_in;
            seg_first_ff <= seg_first_in;
            colon_ff     <= colon_in;
            valid_ff     <= valid_in;
            cnt_ff       <= cnt_in;
            prefix_ff    <= prefix_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         out_valid_ff  <= ok;
         out_prefix_ff <= ok && colon_step;
         out_plen_ff   <= (ok && colon_step) ? LEN_OUT_W'(prefix_step) : '0;
         out_llen_ff   <= ok ? LEN_OUT_W'(local_bytes) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2-2*LEN_OUT_W){1'b0}},
                        out_llen_ff, out_plen_ff, out_prefix_ff, out_valid_ff};

endmodule

// File: test/tb_xml_qname_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the XML QName validator core
// Streams UTF-8 strings into the core under the Name, NCName and QName checks,
// predicts each verdict with an independent decoder and character class
// tables, and compares every response item field by field. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_xml_qname_validator_core;
   import xqv_pkg::*;

   localparam logic [MODE_W-1:0] MODE_QNAME_ALIAS = 2'd3;
   localparam int unsigned COLON_CHAR = 'h3A;
   localparam int unsigned LENGTH_MAX = 65535;

   typedef struct packed {
      logic        ok;
      logic        split;
      logic [15:0] prefix_bytes;
      logic [15:0] local_bytes;
   } qname_verdict_type;

   class qname_scoreboard_type;
      qname_verdict_type verdicts_due[$];
      int                errors;
      logic [MODE_W-1:0] mode;
      logic [20:0]       acc;
      logic [1:0]        pend;
      logic              seg_first;
      logic              colon_seen;
      logic              still_ok;
      int unsigned       count;
      int unsigned       prefix_count;

      function new();
         errors = 0;
         mode = MODE_NAME;
         clear();
      endfunction

      function void clear();
         acc = '0;
         pend = '0;
         seg_first = 1'b1;
         colon_seen = 1'b0;
         still_ok = 1'b1;
         count = 0;
         prefix_count = 0;
      endfunction

      function void set_mode(logic [MODE_W-1:0] value);
         mode = (value == MODE_QNAME_ALIAS) ? MODE_QNAME : value;
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction

      static function bit in_range(int unsigned cp, int unsigned lo, int unsigned hi);
         return cp >= lo && cp <= hi;
      endfunction

      static function bit starts_name(int unsigned cp);
         return in_range(cp, 'h3A, 'h3A) || in_range(cp, 'h41, 'h5A) ||
            in_range(cp, 'h5F, 'h5F) || in_range(cp, 'h61, 'h7A) ||
            in_range(cp, 'hC0, 'hD6) || in_range(cp, 'hD8, 'hF6) ||
            in_range(cp, 'hF8, 'h2FF) || in_range(cp, 'h370, 'h37D) ||
            in_range(cp, 'h37F, 'h1FFF) || in_range(cp, 'h200C, 'h200D) ||
            in_range(cp, 'h2070, 'h218F) || in_range(cp, 'h2C00, 'h2FEF) ||
            in_range(cp, 'h3001, 'hD7FF) || in_range(cp, 'hF900, 'hFDCF) ||
            in_range(cp, 'hFDF0, 'hFFFD) || in_range(cp, 'h10000, 'hEFFFF);
      endfunction

      static function bit continues_name(int unsigned cp);
         return starts_name(cp) || in_range(cp, 'h2D, 'h2E) || in_range(cp, 'h30, 'h39) ||
            in_range(cp, 'hB7, 'hB7) || in_range(cp, 'h300, 'h36F) ||
            in_range(cp, 'h203F, 'h2040);
      endfunction

      function void judge_code_point(int unsigned cp, int unsigned offset);
         if (cp == COLON_CHAR && mode != MODE_NAME) begin
            if (mode == MODE_NCNAME || colon_seen || seg_first) begin
               still_ok = 1'b0;
            end else begin
               colon_seen = 1'b1;
               prefix_count = offset;
               seg_first = 1'b1;
            end
            return;
         end
         if (!(seg_first ? starts_name(cp) : continues_name(cp))) begin
            still_ok = 1'b0;
         end
         seg_first = 1'b0;
      endfunction

      function void decode_byte(logic [7:0] b);
         int unsigned offset;
         offset = count;
         if (count >= LENGTH_MAX) begin
            still_ok = 1'b0;
         end else begin
            count++;
         end
         if (pend == 0) begin
            if (b < 'h80) begin
               judge_code_point(32'(b), offset);
            end else if (b >= 'hC2 && b <= 'hDF) begin
               acc = 21'(b & 'h1F);
               pend = 1;
            end else if (b >= 'hE0 && b <= 'hEF) begin
               acc = 21'(b & 'h0F);
               pend = 2;
            end else if (b >= 'hF0 && b <= 'hF4) begin
               acc = 21'(b & 'h07);
               pend = 3;
            end else begin
               still_ok = 1'b0;
            end
            return;
         end
         // Overlong three- and four-byte forms and code points above U+10FFFF are
         // caught on the first continuation byte.
         if (b[7:6] != 2'b10 || (pend == 2 && acc == 0 && b < 'hA0) ||
             (pend == 3 && acc == 0 && b < 'h90) || (pend == 3 && acc == 4 && b > 'h8F)) begin
            still_ok = 1'b0;
            pend = 0;
            acc = '0;
            return;
         end
         acc = {acc[14:0], b[5:0]};
         pend--;
         if (pend == 0) begin
            judge_code_point(32'(acc), offset);
            acc = '0;
         end
      endfunction

      function void note_item(logic [7:0] b, logic last, logic empty);
         qname_verdict_type v;
         if (!empty) begin
            decode_byte(b);
         end
         if (!last) begin
            return;
         end
         v.ok = still_ok && pend == 0 && !seg_first;
         v.split = v.ok && colon_seen;
         v.prefix_bytes = v.split ? 16'(prefix_count) : 16'd0;
         if (!v.ok) begin
            v.local_bytes = '0;
         end else begin
            v.local_bytes = colon_seen ? 16'(count - prefix_count - 1) : 16'(count);
         end
         verdicts_due.push_back(v);
         clear();
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_verdict(logic [RSP_DATA_W-1:0] data);
         qname_verdict_type want;
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, data);
            errors++;
            return;
         end
         want = verdicts_due.pop_front();
         compare("is_valid", want.ok, data[0]);
         compare("has_prefix", want.split, data[1]);
         compare("prefix_length", want.prefix_bytes, data[17:2]);
         compare("local_length", want.local_bytes, data[33:18]);
      endfunction
   endclass

   localparam int CYCLE_LIMIT   = 3000000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_BYTES   = 100;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [MODE_W-1:0]     csr_wdata = MODE_NAME;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   qname_scoreboard_type sb;
   logic [7:0]           text[$];
   int                   cycles = 0;
   int                   gap_max = 0;
   int                   burst_left = 0;
   int                   stall_left = 0;
   logic [7:0]           ready_mask = '0;

   xml_qname_validator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            sb.set_mode(csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            sb.note_item(req_tdata, req_tlast, req_tuser);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_verdict(rsp_tdata);
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(16, 96);
         case ($urandom_range(0, 3))
            0: ready_mask = '1;
            1: ready_mask = 8'($urandom);
            2: ready_mask = 8'($urandom | $urandom);
            default: ready_mask = 8'($urandom & $urandom);
         endcase
      end
      stall_left--;
      ready_mask = {ready_mask[6:0], ready_mask[7]};
      rsp_tready <= ready_mask[0];
   end

   task automatic drive_item(logic [7:0] data, logic last, logic empty);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tlast <= last;
      req_tuser <= empty;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;
      req_tuser <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic [MODE_W-1:0] value);
      settle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      burst_left = 0;
   endtask

   task automatic send_text(bit marker_end);
      if (text.size() == 0) begin
         drive_item(8'($urandom), 1'b1, 1'b1);
      end else begin
         foreach (text[i]) begin
            drive_item(text[i], (i == text.size() - 1) && !marker_end, 1'b0);
         end
         if (marker_end) begin
            drive_item(8'($urandom), 1'b1, 1'b1);
         end
      end
   endtask

   function automatic int unsigned edge_cp(int idx);
      case (idx)
         0: return 'hC0;
         1: return 'hD7;
         2: return 'hF7;
         3: return 'h2FF;
         4: return 'h37D;
         5: return 'h37E;
         6: return 'h1FFF;
         7: return 'h200C;
         8: return 'h200E;
         9: return 'h218F;
         10: return 'h2FEF;
         11: return 'h3000;
         12: return 'hD7FF;
         13: return 'hD800;
         14: return 'hFDCF;
         15: return 'hFDD0;
         16: return 'hFFFD;
         17: return 'hFFFE;
         18: return 'hEFFFF;
         19: return 'hF0000;
         20: return 'h36F;
         21: return 'h203F;
         22: return 'h2040;
         default: return 'h10FFFF;
      endcase
   endfunction

   function automatic int unsigned pick_letter();
      int unsigned r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 'h61 + r : 'h41 + r - 26;
   endfunction

   function automatic int unsigned pick_cp();
      case ($urandom_range(0, 15))
         5: return 'h5F;
         6: return 'h30 + $urandom_range(0, 9);
         7: return $urandom_range(0, 1) ? 'h2D : 'h2E;
         8: return COLON_CHAR;
         9: return $urandom_range(0, 1) ? 'hB7 : $urandom_range('h300, 'h36F);
         10: return $urandom_range('h80, 'h7FF);
         11: return $urandom_range('h800, 'hFFFF);
         12: return $urandom_range('h10000, 'h10FFFF);
         13: return edge_cp($urandom_range(0, 23));
         14: return $urandom_range(0, 'h7F);
         default: return pick_letter();
      endcase
   endfunction

   task automatic put_cp(int unsigned cp);
      if (cp < 'h80) begin
         text.push_back(8'(cp));
      end else if (cp < 'h800) begin
         text.push_back(8'('hC0 | (cp >> 6)));
         text.push_back(8'('h80 | (cp & 'h3F)));
      end else if (cp < 'h10000) begin
         text.push_back(8'('hE0 | (cp >> 12)));
         text.push_back(8'('h80 | ((cp >> 6) & 'h3F)));
         text.push_back(8'('h80 | (cp & 'h3F)));
      end else begin
         text.push_back(8'('hF0 | (cp >> 18)));
         text.push_back(8'('h80 | ((cp >> 12) & 'h3F)));
         text.push_back(8'('h80 | ((cp >> 6) & 'h3F)));
         text.push_back(8'('h80 | (cp & 'h3F)));
      end
   endtask

   task automatic build_text();
      int n;
      int split;
      int pos;
      text.delete();
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 6)) text.push_back(8'($urandom));
         return;
      end
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      split = ($urandom_range(0, 9) < 4) ? $urandom_range(1, n) : -1;
      for (int i = 0; i < n; i++) begin
         if (i == split) begin
            put_cp(COLON_CHAR);
         end
         if ((i == 0 || i == split) && $urandom_range(0, 9) < 7) begin
            put_cp(pick_letter());
         end else begin
            put_cp(pick_cp());
         end
      end
      case ($urandom_range(0, 19))
         0, 1: begin
            pos = $urandom_range(0, text.size() - 1);
            text[pos] = 8'($urandom);
         end
         2: begin
            if (text.size() > 1) begin
               void'(text.pop_back());
            end
         end
         3: text.insert($urandom_range(0, text.size()), 8'h80);
         default: ;
      endcase
   endtask

   task automatic random_phase(logic [MODE_W-1:0] value, int bytes);
      int sent;
      int ending;
      sent = 0;
      write_mode(value);
      while (sent < bytes) begin
         build_text();
         if ($urandom_range(0, 19) == 0) begin
            drive_item(8'($urandom), 1'b0, 1'b1);
         end
         ending = $urandom_range(0, 19);
         if (ending == 0) begin
            text.delete();
         end
         sent += text.size() + 1;
         send_text(ending == 1 || ending == 2);
      end
   endtask

   initial begin
      logic [MODE_W-1:0] phase_modes[8];
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset value of the check mode: a lone colon is a valid Name.
      gap_max = 3;
      text = {8'h3A};
      send_text(1'b0);

      write_mode(MODE_QNAME);
      text = {8'h61, 8'h3A, 8'h62};
      send_text(1'b0);
      text = {8'h3A, 8'h61};
      send_text(1'b0);
      text = {8'h61, 8'h3A};
      send_text(1'b0);
      text.delete();
      send_text(1'b0);
      drive_item(8'h00, 1'b0, 1'b1);
      text = {8'hFF};
      send_text(1'b0);
      text = {8'h62};
      send_text(1'b1);
      text = {8'h80};
      send_text(1'b0);
      text = {8'h00};
      send_text(1'b0);
      text = {8'hC1};
      send_text(1'b0);
      text = {8'hE0, 8'h80, 8'h80};
      send_text(1'b0);
      text = {8'hF4, 8'h90, 8'h80, 8'h80};
      send_text(1'b0);
      text = {8'hED, 8'hA0, 8'h80};
      send_text(1'b0);
      text = {8'hC3, 8'h41};
      send_text(1'b0);
      text = {8'hC3};
      send_text(1'b0);

      phase_modes[0] = MODE_NAME;
      phase_modes[1] = MODE_NCNAME;
      phase_modes[2] = MODE_QNAME;
      phase_modes[3] = MODE_QNAME_ALIAS;
      for (int i = 4; i < 8; i++) begin
         phase_modes[i] = MODE_W'($urandom_range(0, 3));
      end
      for (int i = 0; i < 8; i++) begin
         gap_max = (i % 3 == 0) ? 0 : $urandom_range(1, 8);
         random_phase(phase_modes[i], PHASE_BYTES);
      end

      settle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/xqv_pkg.sv
rtl/core/xqv_front.sv
rtl/core/xqv_queue.sv
rtl/core/xqv_back.sv
rtl/core/xml_qname_validator_core.sv
test/tb_xml_qname_validator_core.sv
